### rtl/dfas_pkg.sv
// Shared types and constants for the binary64 adder/subtractor.
package dfas_pkg;

   localparam int WordWidth = 64;
   localparam int ExpWidth  = 11;
   localparam int CntWidth  = 7;
   localparam int ExpSWidth = 13;

   localparam logic [CntWidth-1:0]  MaxAlign = 7'd64;
   localparam logic [ExpWidth-1:0]  ExpAllOnes = 11'h7FF;
   localparam logic [ExpSWidth-1:0] ExpTop = 13'sd2047;

   typedef enum logic {
      SHIFT_RIGHT_ARITH = 1'b0,
      SHIFT_LEFT        = 1'b1
   } shift_dir_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ALIGN = 5'b00010,
      ST_ADD   = 5'b00100,
      ST_NORM  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Signed fraction with hidden bit at bit 62, stored fraction at 61..10.
   function automatic logic [WordWidth-1:0] unpack_frac(input logic [WordWidth-1:0] bits);
      logic [WordWidth-1:0] f;
      f = {1'b0, 1'b1, bits[51:0], 10'b0};
      if (bits[63]) begin
         f = ~f + 64'd1;
      end
      return f;
   endfunction

endpackage

### rtl/dfas_shift.sv
// One-bit shift unit shared by the alignment and normalization steps.
module dfas_shift (
   input  dfas_pkg::shift_dir_type  dir,
   input  logic [63:0]              data_in,
   output logic [63:0]              data_out
);

   always_comb begin
      unique case (dir)
         dfas_pkg::SHIFT_RIGHT_ARITH: data_out = {data_in[63], data_in[63:1]};
         dfas_pkg::SHIFT_LEFT:        data_out = {data_in[62:0], 1'b0};
         default:                     data_out = data_in;
      endcase
   end

endmodule

### rtl/double_float_add_subtract.sv
// Top level: binary64 add/subtract with truncation, one shared bit shifter.
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_valid, req_stall  | req_func, req_operand_a, req_operand_b
//   rsp      | out       | rsp_valid, rsp_stall  | rsp_result_bits
//
// After accept a beat aligns the operand with the smaller exponent by the gap,
// capped at 64, adds, then normalizes with at most 62 left shifts; both shift
// steps run one bit a cycle through the single shift unit. An exact zero sum
// skips normalizing and goes straight to the result.
// Reset (synchronous) returns the sequencer to idle and drops any pending result.
// req_stall is high from accept until the result beat is taken; rsp_stall holds it.
module double_float_add_subtract (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_bits
);

   dfas_pkg::state_type state_ff, state_in;
   logic [63:0] big_ff, big_in;
   logic [63:0] small_ff, small_in;
   logic [63:0] mag_ff, mag_in;
   logic [63:0] result_ff, result_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [12:0] exp_ff, exp_in;
   logic        a_small_ff, a_small_in;
   logic        sub_ff, sub_in;
   logic        sign_ff, sign_in;

   dfas_pkg::shift_dir_type sh_dir;
   logic [63:0] sh_data, sh_out;

   logic [10:0] ea, eb, exp_gap;
   logic        a_gt;
   logic [63:0] fa, fb, sum, sum_abs;

   dfas_shift u_shift (
      .dir      (sh_dir),
      .data_in  (sh_data),
      .data_out (sh_out)
   );

   assign ea      = req_operand_a[62:52];
   assign eb      = req_operand_b[62:52];
   assign a_gt    = ea > eb;
   assign exp_gap = a_gt ? (ea - eb) : (eb - ea);

   assign sh_dir  = (state_ff == dfas_pkg::ST_NORM) ? dfas_pkg::SHIFT_LEFT
                                                    : dfas_pkg::SHIFT_RIGHT_ARITH;
   assign sh_data = (state_ff == dfas_pkg::ST_NORM) ? mag_ff : small_ff;

   assign fa  = a_small_ff ? small_ff : big_ff;
   assign fb  = a_small_ff ? big_ff : small_ff;
   assign sum = sub_ff ? ({fa[63], fa[63:1]} - {fb[63], fb[63:1]})
                       : ({fa[63], fa[63:1]} + {fb[63], fb[63:1]});
   assign sum_abs = sum[63] ? (~sum + 64'd1) : sum;

   assign req_stall       = (state_ff != dfas_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == dfas_pkg::ST_DONE);
   assign rsp_result_bits = result_ff;

   always_comb begin
      state_in   = state_ff;
      big_in     = big_ff;
      small_in   = small_ff;
      mag_in     = mag_ff;
      result_in  = result_ff;
      cnt_in     = cnt_ff;
      exp_in     = exp_ff;
      a_small_in = a_small_ff;
      sub_in     = sub_ff;
      sign_in    = sign_ff;
      unique case (state_ff)
         dfas_pkg::ST_IDLE: begin
            if (req_valid) begin
               sub_in     = req_func;
               a_small_in = !a_gt;
               big_in     = a_gt ? dfas_pkg::unpack_frac(req_operand_a)
                                 : dfas_pkg::unpack_frac(req_operand_b);
               small_in   = a_gt ? dfas_pkg::unpack_frac(req_operand_b)
                                 : dfas_pkg::unpack_frac(req_operand_a);
               exp_in     = {2'b00, (a_gt ? ea : eb)} + 13'd1;
               cnt_in     = (exp_gap >= 11'd64) ? dfas_pkg::MaxAlign : exp_gap[6:0];
               state_in   = dfas_pkg::ST_ALIGN;
            end
         end
         dfas_pkg::ST_ALIGN: begin
            if (cnt_ff == 7'd0) begin
               state_in = dfas_pkg::ST_ADD;
            end else begin
               small_in = sh_out;
               cnt_in   = cnt_ff - 7'd1;
            end
         end
         dfas_pkg::ST_ADD: begin
            if (sum == 64'd0) begin
               result_in = 64'd0;
               state_in  = dfas_pkg::ST_DONE;
            end else begin
               sign_in  = sum[63];
               mag_in   = sum_abs;
               state_in = dfas_pkg::ST_NORM;
            end
         end
         dfas_pkg::ST_NORM: begin
            if (mag_ff[62]) begin
               // pack: flush low exponents, saturate high ones to infinity
               if ($signed(exp_ff) <= 13'sd0) begin
                  result_in = {sign_ff, 63'd0};
               end else if ($signed(exp_ff) >= $signed(dfas_pkg::ExpTop)) begin
                  result_in = {sign_ff, dfas_pkg::ExpAllOnes, 52'd0};
               end else begin
                  result_in = {sign_ff, exp_ff[10:0], mag_ff[61:10]};
               end
               state_in = dfas_pkg::ST_DONE;
            end else begin
               mag_in = sh_out;
               exp_in = exp_ff - 13'd1;
            end
         end
         dfas_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = dfas_pkg::ST_IDLE;
            end
         end
         default: state_in = dfas_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfas_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      big_ff     <= big_in;
      small_ff   <= small_in;
      mag_ff     <= mag_in;
      result_ff  <= result_in;
      cnt_ff     <= cnt_in;
      exp_ff     <= exp_in;
      a_small_ff <= a_small_in;
      sub_ff     <= sub_in;
      sign_ff    <= sign_in;
   end

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfas_pkg::ST_ALIGN) |-> (cnt_ff <= dfas_pkg::MaxAlign))
      else $error("alignment count above cap");

   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfas_pkg::ST_NORM) |-> (mag_ff != 64'd0))
      else $error("normalizing a zero magnitude");

   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfas_pkg::ST_NORM) |-> (mag_ff[63] == 1'b0))
      else $error("magnitude overflowed bit 63");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_bits)))
      else $error("stalled result changed");

endmodule

### dv/tb_top.sv
// Testbench for the binary64 adder/subtractor: directed and random beats vs a local predictor.
`timescale 1ns / 1ps
module tb_top;

   localparam int CycleLimit = 2_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_bits;

   logic [63:0] sum_queue[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct;
   int          stall_pct;
   int          hold_cycles = 0;
   logic        hold_armed = 1'b0;
   logic        hold_taken = 1'b0;

   double_float_add_subtract u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_bits(rsp_result_bits)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Arithmetic right shift with saturation at 64 and beyond.
   function automatic logic [63:0] shift_frac(input logic [63:0] x, input int n);
      if (n >= 64) begin
         return x[63] ? '1 : '0;
      end
      return $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] signed_frac(input logic [63:0] bits);
      logic [63:0] f;
      f = {2'b01, bits[51:0], 10'b0};
      if (bits[63]) begin
         f = ~f + 64'd1;
      end
      return f;
   endfunction

   function automatic logic [63:0] predict_sum(input logic sub, input logic [63:0] a,
                                               input logic [63:0] b);
      logic [63:0] fa, fb, total, mag, sgn;
      int          ea, eb, e, biased;
      fa = signed_frac(a);
      fb = signed_frac(b);
      ea = int'(a[62:52]) - 1023;
      eb = int'(b[62:52]) - 1023;
      if (ea > eb) begin
         fb = shift_frac(fb, ea - eb);
         e = ea;
      end else begin
         fa = shift_frac(fa, eb - ea);
         e = eb;
      end
      fa = shift_frac(fa, 1);
      fb = shift_frac(fb, 1);
      total = sub ? fa - fb : fa + fb;
      e = e + 1;
      if (total == 64'd0) begin
         return 64'd0;
      end
      sgn = {total[63], 63'd0};
      mag = total[63] ? ~total + 64'd1 : total;
      while (mag[62] == 1'b0) begin
         mag = mag << 1;
         e--;
      end
      biased = e + 1023;
      if (biased <= 0) begin
         return sgn;
      end
      if (biased >= 2047) begin
         return sgn | {1'b0, dfas_pkg::ExpAllOnes, 52'd0};
      end
      return sgn | (64'(biased) << 52) | {12'd0, mag[61:10]};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // Offer one beat; hold it until accepted.
   task automatic send_beat(input logic func, input logic [63:0] a, input logic [63:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sum_queue.push_back(predict_sum(func, a, b));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (sum_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sum_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_result_bits, 64'd0);
         end else begin
            if (rsp_result_bits !== sum_queue[0]) begin
               report_mismatch("result_bits", rsp_result_bits, sum_queue[0]);
            end
            void'(sum_queue.pop_front());
         end
      end
   end

   // Start the long hold once when armed, then count it down.
   always @(negedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_taken  <= 1'b1;
         hold_cycles <= 400;
         rsp_stall   <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [63:0] rand_word;
      return {$urandom, $urandom};
   endfunction

   // Operands with exponents near each other so the sum actually mixes.
   function automatic logic [63:0] near_word(input logic [63:0] base);
      logic [63:0] w;
      w = rand_word();
      w[62:52] = base[62:52] + 11'($urandom_range(6)) - 11'd3;
      return w;
   endfunction

   task automatic test_directed;
      logic [63:0] one, two;
      one = 64'h3FF0_0000_0000_0000;
      two = 64'h4000_0000_0000_0000;
      send_beat(1'b0, one, one);
      send_beat(1'b1, one, one);                               // exact zero
      send_beat(1'b1, two, one);
      send_beat(1'b0, one, 64'hBFF0_0000_0000_0000);
      send_beat(1'b0, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF); // overflow
      send_beat(1'b1, 64'hFFEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF);
      send_beat(1'b1, 64'h0010_0000_0000_0001, 64'h0010_0000_0000_0000); // underflow
      send_beat(1'b1, 64'h8010_0000_0000_0000, 64'h8010_0000_0000_0001);
      send_beat(1'b0, one, 64'h0000_0000_0000_0001);           // long alignment
      send_beat(1'b0, 64'h8000_0000_0000_0001, 64'h7FF0_0000_0000_0000);
      send_beat(1'b0, 64'h7FF8_0000_0000_0000, 64'hFFF0_0000_0000_0000); // NaN, inf
      send_beat(1'b0, 64'd0, 64'd0);
      send_beat(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
      send_beat(1'b0, 64'h3FF0_0000_0000_0000, 64'h3C00_0000_0000_0000); // shift 63
      send_beat(1'b0, 64'hBFF0_0000_0000_0000, 64'h3BF0_0000_0000_0000); // shift 64
      send_beat(1'b1, 64'h3FFF_FFFF_FFFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFE);
      drain();
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      logic [63:0] a;
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (count) begin
         a = rand_word();
         if ($urandom_range(3) == 0) begin
            send_beat(1'($urandom), a, rand_word());
         end else begin
            send_beat(1'($urandom), a, near_word(a));
         end
      end
      drain();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      stall_pct     = 0;
      @(negedge clock);
      hold_armed = 1'b1;
      repeat (20) begin
         send_beat(1'($urandom), rand_word(), rand_word());
      end
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(250, 0, 0);
      test_random(200, 63, 0);
      test_random(200, 0, 63);
      test_random(200, 31, 31);
      test_backpressure();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
